// ===== design/two_level_block_layout_address_macros.svh =====
// ---------------------------------------------------------------------------
// two_level_block_layout_address_macros
// assertion macros shared by the layout address design
// ---------------------------------------------------------------------------
`ifndef TWO_LEVEL_BLOCK_LAYOUT_ADDRESS_MACROS_SVH
`define TWO_LEVEL_BLOCK_LAYOUT_ADDRESS_MACROS_SVH

// implication checked in the same cycle
`define TLBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// plain invariant
`define TLBA_ASSERT_ALWAYS(lbl, cond, msg) \
    `TLBA_ASSERT_NOW(lbl, 1'b1, cond, msg)

`endif

// ===== design/tlba_pkg.sv =====
// ---------------------------------------------------------------------------
// tlba_pkg
// types, register indexes and helper functions of the layout address design
// ---------------------------------------------------------------------------
`default_nettype none

package tlba_pkg;

    localparam int IDX_W  = 12;
    localparam int DIM_W  = 13;
    localparam int ADDR_W = 24;
    localparam int CIDX_W = 3;

    typedef enum logic [CIDX_W-1:0] {
        REG_MATRIX_ROWS = 3'd0,
        REG_MATRIX_COLS = 3'd1,
        REG_BIG_ROWS    = 3'd2,
        REG_BIG_COLS    = 3'd3,
        REG_SMALL_ROWS  = 3'd4,
        REG_SMALL_COLS  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [IDX_W-1:0]  ri;
        logic [IDX_W-1:0]  ci;
        logic              oor;
        logic [IDX_W-1:0]  qa;
        logic [IDX_W-1:0]  qb;
        logic [DIM_W-1:0]  ra;
        logic [DIM_W-1:0]  rb;
        logic [IDX_W-1:0]  li;
        logic [IDX_W-1:0]  lj;
        logic [DIM_W-1:0]  bm;
        logic [DIM_W-1:0]  bn;
        logic [DIM_W-1:0]  sh;
        logic [DIM_W-1:0]  sw;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  w;
        logic [ADDR_W-1:0] t1;
        logic [ADDR_W-1:0] t2;
        logic [ADDR_W-1:0] t3;
        logic [ADDR_W-1:0] t4;
        logic [ADDR_W-1:0] t5;
        logic [ADDR_W-1:0] s12;
    } pipe_t;

    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] quo;
    } div_t;

    // two restoring division steps
    function automatic div_t div_step2(div_t cur, logic [DIM_W-1:0] d);
        div_t            r;
        logic [DIM_W:0]  tmp;
        r = cur;
        for (int i = 0; i < 2; i++) begin
            tmp = {r.rem, r.quo[IDX_W-1]};
            if (tmp >= {1'b0, d}) begin
                r.rem = DIM_W'(tmp - {1'b0, d});
                r.quo = {r.quo[IDX_W-2:0], 1'b1};
            end else begin
                r.rem = tmp[DIM_W-1:0];
                r.quo = {r.quo[IDX_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] min_dim(logic [DIM_W-1:0] a,
                                                 logic [DIM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [ADDR_W-1:0] mul_lo(logic [DIM_W-1:0] a,
                                                 logic [DIM_W-1:0] b);
        logic [2*DIM_W-1:0] p;
        p = a * b;
        return p[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/two_level_block_layout_address.sv =====
// ---------------------------------------------------------------------------
// two_level_block_layout_address
// maps a row/column coordinate to its address in a two-level blocked layout
// ---------------------------------------------------------------------------
// channel   ports                                  dir
// s_        s_valid s_ready s_row_index s_col_index in
// m_        m_valid m_ready m_layout_address        out
//           m_out_of_range
// cfg_      cfg_wen cfg_index cfg_wdata             in
//
// one item per cycle while the output is not stalled, set by the 18-stage pipeline
// (two 6-stage pipelined dividers, two bits of quotient per stage)
// reset clears all stage valid bits and sets every dimension register to 1
// each stage moves when the next one is empty or moving, so bubbles close up
// and a stalled output holds every item in place
// ---------------------------------------------------------------------------
`default_nettype none

`include "two_level_block_layout_address_macros.svh"

module two_level_block_layout_address #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [tlba_pkg::IDX_W-1:0]    s_row_index,
    input  wire logic [tlba_pkg::IDX_W-1:0]    s_col_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tlba_pkg::ADDR_W-1:0]        m_layout_address,
    output logic                               m_out_of_range,
    input  wire logic                          cfg_wen,
    input  wire logic [tlba_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [tlba_pkg::DIM_W-1:0]    cfg_wdata
);
    import tlba_pkg::*;

    localparam int NSTG   = 18;
    localparam int DA_LO  = 1;
    localparam int DA_HI  = 6;
    localparam int ST_BLK = 7;
    localparam int ST_SML = 8;
    localparam int DB_LO  = 9;
    localparam int DB_HI  = 14;
    localparam int ST_HW  = 15;
    localparam int ST_MUL = 16;
    localparam int ST_SUM = 17;

    logic [DIM_W-1:0] mr_reg, mc_reg, br_reg, bc_reg, dr_reg, dc_reg;
    logic [DIM_W-1:0] eff_next;

    pipe_t            stg_reg [NSTG];
    pipe_t            stg_next[NSTG];
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  adv;

    // saturated register value
    always_comb begin
        if (cfg_wdata == '0) begin
            eff_next = DIM_W'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_DIM)) begin
            eff_next = DIM_W'(MAX_DIM);
        end else begin
            eff_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mr_reg <= DIM_W'(1);
            mc_reg <= DIM_W'(1);
            br_reg <= DIM_W'(1);
            bc_reg <= DIM_W'(1);
            dr_reg <= DIM_W'(1);
            dc_reg <= DIM_W'(1);
        end else if (cfg_wen) begin
            case (cfg_idx_t'(cfg_index))
                REG_MATRIX_ROWS: mr_reg <= eff_next;
                REG_MATRIX_COLS: mc_reg <= eff_next;
                REG_BIG_ROWS:    br_reg <= eff_next;
                REG_BIG_COLS:    bc_reg <= eff_next;
                REG_SMALL_ROWS:  dr_reg <= eff_next;
                REG_SMALL_COLS:  dc_reg <= eff_next;
                default: ;
            endcase
        end
    end

    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];

    always_comb begin
        div_t da, db;
        for (int k = 0; k < NSTG; k++) begin
            if (k == 0) begin
                stg_next[k]     = '0;
                stg_next[k].ri  = s_row_index;
                stg_next[k].ci  = s_col_index;
                stg_next[k].oor = ({1'b0, s_row_index} >= mr_reg) ||
                                  ({1'b0, s_col_index} >= mc_reg);
                stg_next[k].qa  = s_row_index;
                stg_next[k].qb  = s_col_index;
            end else begin
                stg_next[k] = stg_reg[k-1];
            end
            da = '{rem: stg_reg[(k == 0) ? 0 : k-1].ra, quo: stg_reg[(k == 0) ? 0 : k-1].qa};
            db = '{rem: stg_reg[(k == 0) ? 0 : k-1].rb, quo: stg_reg[(k == 0) ? 0 : k-1].qb};
            if (k >= DA_LO && k <= DA_HI) begin
                da = div_step2(da, br_reg);
                db = div_step2(db, bc_reg);
                stg_next[k].ra = da.rem;
                stg_next[k].qa = da.quo;
                stg_next[k].rb = db.rem;
                stg_next[k].qb = db.quo;
            end else if (k >= DB_LO && k <= DB_HI) begin
                da = div_step2(da, stg_reg[k-1].sh);
                db = div_step2(db, stg_reg[k-1].sw);
                stg_next[k].ra = da.rem;
                stg_next[k].qa = da.quo;
                stg_next[k].rb = db.rem;
                stg_next[k].qb = db.quo;
            end else if (k == ST_BLK) begin
                // large block size, edge blocks shrink
                stg_next[k].li = stg_reg[k-1].ra[IDX_W-1:0];
                stg_next[k].lj = stg_reg[k-1].rb[IDX_W-1:0];
                stg_next[k].bm = min_dim(br_reg, mr_reg -
                    {1'b0, stg_reg[k-1].ri - stg_reg[k-1].ra[IDX_W-1:0]});
                stg_next[k].bn = min_dim(bc_reg, mc_reg -
                    {1'b0, stg_reg[k-1].ci - stg_reg[k-1].rb[IDX_W-1:0]});
            end else if (k == ST_SML) begin
                stg_next[k].sh = min_dim(stg_reg[k-1].bm, dr_reg);
                stg_next[k].sw = min_dim(stg_reg[k-1].bn, dc_reg);
                stg_next[k].t1 = mul_lo({1'b0, stg_reg[k-1].ri - stg_reg[k-1].li},
                                        mc_reg);
                stg_next[k].t2 = mul_lo(stg_reg[k-1].bm,
                                        {1'b0, stg_reg[k-1].ci - stg_reg[k-1].lj});
                stg_next[k].qa = stg_reg[k-1].li;
                stg_next[k].qb = stg_reg[k-1].lj;
                stg_next[k].ra = '0;
                stg_next[k].rb = '0;
            end else if (k == ST_HW) begin
                // small block size, edge blocks shrink
                stg_next[k].h  = min_dim(stg_reg[k-1].sh, stg_reg[k-1].bm -
                    {1'b0, stg_reg[k-1].li - stg_reg[k-1].ra[IDX_W-1:0]});
                stg_next[k].w  = min_dim(stg_reg[k-1].sw, stg_reg[k-1].bn -
                    {1'b0, stg_reg[k-1].lj - stg_reg[k-1].rb[IDX_W-1:0]});
                stg_next[k].t3 = mul_lo({1'b0, stg_reg[k-1].li -
                                         stg_reg[k-1].ra[IDX_W-1:0]},
                                        stg_reg[k-1].bn);
                stg_next[k].s12 = stg_reg[k-1].t1 + stg_reg[k-1].t2;
            end else if (k == ST_MUL) begin
                stg_next[k].t4 = mul_lo({1'b0, stg_reg[k-1].lj -
                                         stg_reg[k-1].rb[IDX_W-1:0]},
                                        stg_reg[k-1].h);
                stg_next[k].t5 = mul_lo(stg_reg[k-1].ra, stg_reg[k-1].w);
                stg_next[k].s12 = stg_reg[k-1].s12 + stg_reg[k-1].t3;
            end else if (k == ST_SUM) begin
                if (stg_reg[k-1].oor) begin
                    stg_next[k].s12 = '0;
                end else begin
                    stg_next[k].s12 = stg_reg[k-1].s12 + stg_reg[k-1].t4 +
                                      stg_reg[k-1].t5 +
                                      ADDR_W'(stg_reg[k-1].rb);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (adv[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign m_valid          = vld_reg[NSTG-1];
    assign m_layout_address = stg_reg[NSTG-1].s12;
    assign m_out_of_range   = stg_reg[NSTG-1].oor;

    `TLBA_ASSERT_NOW(a_oor_zero, m_valid && m_out_of_range, m_layout_address == '0, "address not zero for out-of-range item")
    `TLBA_ASSERT_NOW(a_stall_src, !s_ready, m_valid && !m_ready, "input stalled while output moves")
    `TLBA_ASSERT_ALWAYS(a_dims_nonzero, mr_reg != '0 && mc_reg != '0 && br_reg != '0 && bc_reg != '0 && dr_reg != '0 && dc_reg != '0, "dimension register holds zero")

endmodule

`default_nettype wire
